[hdl/bitmap_id_allocator_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the bitmap ID allocator
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef BITMAP_ID_ALLOCATOR_MACROS_SVH
`define BITMAP_ID_ALLOCATOR_MACROS_SVH

`ifndef SYNTHESIS
// property must hold on every clock edge outside reset
`define BIA_ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// consequent must hold in the cycle after the antecedent
`define BIA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define BIA_ASSERT_ALWAYS(label, clk, rst, prop, msg)
`define BIA_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

[hdl/bia_pkg.sv]
// ----------------------------------------------------------------------------
// bia_pkg
// Shared sizes, request codes and the word status record of the allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bia_pkg;

   localparam int MAX_IDS       = 256;
   localparam int WORD_BITS     = 32;
   localparam int VALUE_BITS    = 64;
   localparam int NWORDS        = (MAX_IDS + WORD_BITS - 1) / WORD_BITS;
   localparam int ID_BITS       = $clog2(MAX_IDS);
   localparam int COUNT_BITS    = ID_BITS + 1;
   localparam int BIT_IDX_BITS  = $clog2(WORD_BITS);
   localparam int WORD_IDX_BITS = $clog2(NWORDS);
   localparam int WCOUNT_BITS   = WORD_IDX_BITS + 1;

   typedef enum logic [1:0] {
      MODE_ALLOC  = 2'd0,
      MODE_FIND   = 2'd1,
      MODE_REMOVE = 2'd2
   } mode_type;

   typedef struct packed {
      logic [WORD_BITS-1:0]    valid_mask;
      logic [WORD_BITS-1:0]    free_mask;
      logic                    any_free;
      logic [BIT_IDX_BITS-1:0] low_bit;
   } word_stat_type;

endpackage

`default_nettype wire

[hdl/bia_word_unit.sv]
// ----------------------------------------------------------------------------
// bia_word_unit
// Shared bitmap word unit: masks IDs beyond the active count, finds free
// bits and encodes the lowest free bit of one word.
// ----------------------------------------------------------------------------
`default_nettype none

module bia_word_unit import bia_pkg::*; (
   input  wire logic [WORD_IDX_BITS-1:0] word_idx,
   input  wire logic [WORD_BITS-1:0]     used_word,
   input  wire logic [COUNT_BITS-1:0]    active_n,
   output word_stat_type                 stat
);

   logic [WORD_BITS-1:0]    valid_mask;
   logic [WORD_BITS-1:0]    free_mask;
   logic [WORD_BITS-1:0]    lowest;
   logic [BIT_IDX_BITS-1:0] low_bit;

   always_comb begin
      for (int b = 0; b < WORD_BITS; b++) begin
         valid_mask[b] = COUNT_BITS'({word_idx, b[BIT_IDX_BITS-1:0]}) < active_n;
      end
   end

   assign free_mask = ~used_word & valid_mask;
   assign lowest    = free_mask & (~free_mask + WORD_BITS'(1));

   // one-hot to index, one bit of the index at a time
   always_comb begin
      for (int k = 0; k < BIT_IDX_BITS; k++) begin
         low_bit[k] = 1'b0;
         for (int b = 0; b < WORD_BITS; b++) begin
            if (b[k]) begin
               low_bit[k] = low_bit[k] | lowest[b];
            end
         end
      end
   end

   assign stat.valid_mask = valid_mask;
   assign stat.free_mask  = free_mask;
   assign stat.any_free   = |free_mask;
   assign stat.low_bit    = low_bit;

endmodule

`default_nettype wire

[hdl/bia_value_ram.sv]
// ----------------------------------------------------------------------------
// bia_value_ram
// Value store, one entry per ID, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bia_value_ram import bia_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  wr_en,
   input  wire logic [ID_BITS-1:0]    wr_addr,
   input  wire logic [VALUE_BITS-1:0] wr_data,
   input  wire logic                  rd_en,
   input  wire logic [ID_BITS-1:0]    rd_addr,
   output logic      [VALUE_BITS-1:0] rd_data
);

   logic [VALUE_BITS-1:0] mem_ff [MAX_IDS];
   logic [VALUE_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[hdl/bitmap_id_allocator.sv]
// ----------------------------------------------------------------------------
// bitmap_id_allocator
// ID allocator over a used-bitmap with one stored value per ID. Allocate
// scans bitmap words from a rotating pointer, find reads the value store,
// remove frees an ID.
//
//   channel  dir  handshake              payload
//   req      in   req_valid/req_ready    req_mode, req_id, req_entry_value
//   rsp      out  rsp_valid/rsp_ready    rsp_result_id, rsp_result_value,
//                                        rsp_status
//   csr      in   csr_write_enable       csr_write_data (id_count)
//
// allocate: scans bitmap words (1 to 8) until one has a free bit, then the response
// find: bitmap check with value store read, then data fetch, then the response
// remove: bitmap clear, then the response; unknown mode or allocate at zero count: the response only
// the value store has one port pair, the word unit checks one word a cycle
// reset clears the bitmap, the scan pointer and sets id_count to 256
// a beat waits in the response register while rsp_ready is low
// ----------------------------------------------------------------------------
`default_nettype none

`include "bitmap_id_allocator_macros.svh"

module bitmap_id_allocator import bia_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [1:0]            req_mode,
   input  wire logic [7:0]            req_id,
   input  wire logic [63:0]           req_entry_value,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic      [7:0]            rsp_result_id,
   output logic      [63:0]           rsp_result_value,
   output logic                       rsp_status,
   input  wire logic                  csr_write_enable,
   input  wire logic [8:0]            csr_write_data
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_SCAN   = 6'b000010,
      ST_LOOKUP = 6'b000100,
      ST_FETCH  = 6'b001000,
      ST_REMOVE = 6'b010000,
      ST_RESP   = 6'b100000
   } state_type;

   state_type                state_ff, state_in;
   logic [COUNT_BITS-1:0]    count_ff, count_in;
   logic [WORD_BITS-1:0]     used_ff [NWORDS];
   logic [WORD_BITS-1:0]     used_in [NWORDS];
   logic [WORD_IDX_BITS-1:0] scan_ff, scan_in;
   logic [WORD_IDX_BITS-1:0] pass_ff, pass_in;
   logic [1:0]               mode_ff, mode_in;
   logic [ID_BITS-1:0]       id_ff, id_in;
   logic [VALUE_BITS-1:0]    val_ff, val_in;
   logic                     hit_ff, hit_in;
   logic [7:0]               rid_ff, rid_in;
   logic [63:0]              rval_ff, rval_in;
   logic                     rstat_ff, rstat_in;

   logic [COUNT_BITS-1:0]    active_n;
   logic [COUNT_BITS:0]      round_up;
   logic [WCOUNT_BITS-1:0]   words;
   logic [WORD_IDX_BITS-1:0] start_word;
   logic [WCOUNT_BITS-1:0]   scan_next;
   logic [WORD_IDX_BITS-1:0] unit_idx;
   logic [WORD_BITS-1:0]     unit_word;
   word_stat_type            stat;
   logic [BIT_IDX_BITS-1:0]  id_bit;
   logic                     ram_wr_en;
   logic                     ram_rd_en;
   logic [VALUE_BITS-1:0]    ram_rd_data;
   logic                     req_beat;
   logic                     rsp_beat;

   assign req_beat = req_valid && req_ready;
   assign rsp_beat = rsp_valid && rsp_ready;

   // active count and number of words it covers
   assign active_n   = (count_ff > COUNT_BITS'(MAX_IDS)) ? COUNT_BITS'(MAX_IDS) : count_ff;
   assign round_up   = (COUNT_BITS+1)'(active_n) + (COUNT_BITS+1)'(WORD_BITS - 1);
   assign words      = WCOUNT_BITS'(round_up >> BIT_IDX_BITS);
   assign start_word = (WCOUNT_BITS'(scan_ff) >= words) ? '0 : scan_ff;
   assign scan_next  = WCOUNT_BITS'(scan_ff) + WCOUNT_BITS'(1);

   assign id_bit    = id_ff[BIT_IDX_BITS-1:0];
   assign unit_idx  = (state_ff == ST_SCAN) ? scan_ff : id_ff[ID_BITS-1:BIT_IDX_BITS];
   assign unit_word = used_ff[unit_idx];

   bia_word_unit u_word_unit (
      .word_idx  (unit_idx),
      .used_word (unit_word),
      .active_n  (active_n),
      .stat      (stat)
   );

   assign ram_wr_en = (state_ff == ST_SCAN) && stat.any_free;
   assign ram_rd_en = (state_ff == ST_LOOKUP);

   bia_value_ram u_value_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr ({scan_ff, stat.low_bit}),
      .wr_data (val_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (id_ff),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in = state_ff;
      count_in = csr_write_enable ? csr_write_data : count_ff;
      used_in  = used_ff;
      scan_in  = scan_ff;
      pass_in  = pass_ff;
      mode_in  = mode_ff;
      id_in    = id_ff;
      val_in   = val_ff;
      hit_in   = hit_ff;
      rid_in   = rid_ff;
      rval_in  = rval_ff;
      rstat_in = rstat_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               mode_in  = req_mode;
               id_in    = req_id;
               val_in   = req_entry_value;
               rid_in   = req_id;
               rval_in  = '0;
               rstat_in = 1'b1;
               pass_in  = '0;
               case (req_mode)
                  MODE_ALLOC: begin
                     if (words == '0) begin
                        state_in = ST_RESP;
                     end else begin
                        scan_in  = start_word;
                        state_in = ST_SCAN;
                     end
                  end
                  MODE_FIND: begin
                     state_in = ST_LOOKUP;
                  end
                  MODE_REMOVE: begin
                     rstat_in = 1'b0;
                     state_in = ST_REMOVE;
                  end
                  default: begin
                     state_in = ST_RESP;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (stat.any_free) begin
               used_in[scan_ff][stat.low_bit] = 1'b1;
               rid_in   = {scan_ff, stat.low_bit};
               rstat_in = 1'b0;
               state_in = ST_RESP;
            end else begin
               scan_in = (scan_next >= words) ? '0 : scan_next[WORD_IDX_BITS-1:0];
               pass_in = pass_ff + WORD_IDX_BITS'(1);
               if (WCOUNT_BITS'(pass_ff) == words - WCOUNT_BITS'(1)) begin
                  state_in = ST_RESP;
               end
            end
         end
         ST_LOOKUP: begin
            hit_in   = stat.valid_mask[id_bit] && unit_word[id_bit];
            state_in = ST_FETCH;
         end
         ST_FETCH: begin
            rval_in  = hit_ff ? 64'(ram_rd_data) : '0;
            rstat_in = !hit_ff;
            state_in = ST_RESP;
         end
         ST_REMOVE: begin
            used_in[unit_idx][id_bit] = 1'b0;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_beat) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= COUNT_BITS'(MAX_IDS);
         scan_ff  <= '0;
         for (int w = 0; w < NWORDS; w++) begin
            used_ff[w] <= '0;
         end
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         scan_ff  <= scan_in;
         used_ff  <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      pass_ff  <= pass_in;
      mode_ff  <= mode_in;
      id_ff    <= id_in;
      val_ff   <= val_in;
      hit_ff   <= hit_in;
      rid_ff   <= rid_in;
      rval_ff  <= rval_in;
      rstat_ff <= rstat_in;
   end

   assign req_ready        = (state_ff == ST_IDLE);
   assign rsp_valid        = (state_ff == ST_RESP);
   assign rsp_result_id    = rid_ff;
   assign rsp_result_value = rval_ff;
   assign rsp_status       = rstat_ff;

   // checks
   `BIA_ASSERT_ALWAYS(a_no_overlap, clock, reset, !(req_ready && rsp_valid), "request taken while a response is pending")
   `BIA_ASSERT_ALWAYS(a_scan_in_range, clock, reset, (state_ff != ST_SCAN) || (WCOUNT_BITS'(scan_ff) < words), "scan pointer beyond active words")
   `BIA_ASSERT_ALWAYS(a_alloc_id_in_range, clock, reset, !(rsp_valid && (mode_ff == MODE_ALLOC) && !rsp_status) || (COUNT_BITS'(rsp_result_id) < active_n), "allocated id beyond active count")
   `BIA_ASSERT_NEXT(a_alloc_marks_used, clock, reset, (state_ff == ST_SCAN) && stat.any_free, used_ff[$past(scan_ff)][$past(stat.low_bit)], "allocated bit not marked used")

endmodule

`default_nettype wire

[verif/bitmap_id_allocator_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bitmap_id_allocator_tb
// Self-checking bench for the bitmap ID allocator. A driver pushes queued
// allocate, find, remove and unknown-mode requests in bursts, a monitor
// takes responses under a shifting stall pattern and checks each beat
// against a cycle-free predictor of the bitmap, the value store and the
// scan pointer. The ID count register is swept through zero, one, small,
// full and oversized settings between phases.
// ----------------------------------------------------------------------------
module bitmap_id_allocator_tb;
   import bia_pkg::*;

   localparam logic [1:0] MODE_UNKNOWN = 2'd3;
   localparam int READY_ALWAYS = 0;
   localparam int READY_RANDOM = 1;
   localparam int READY_SPARSE = 2;

   typedef struct packed {
      logic [1:0]            mode;
      logic [ID_BITS-1:0]    id;
      logic [VALUE_BITS-1:0] value;
   } request_beat_type;

   typedef struct packed {
      logic [ID_BITS-1:0]    id;
      logic [VALUE_BITS-1:0] value;
      logic                  status;
   } result_beat_type;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [1:0]            req_mode = '0;
   logic [7:0]            req_id = '0;
   logic [63:0]           req_entry_value = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [7:0]            rsp_result_id;
   logic [63:0]           rsp_result_value;
   logic                  rsp_status;
   logic                  csr_write_enable = 1'b0;
   logic [8:0]            csr_write_data = '0;

   request_beat_type      pending_reqs[$];
   result_beat_type       expected_results[$];
   bit                    failed = 1'b0;

   // allocator image
   logic [WORD_BITS-1:0]  used_bits [NWORDS];
   logic [VALUE_BITS-1:0] stored_value [MAX_IDS];
   int unsigned           scan_ptr;
   int unsigned           id_limit;

   int                    burst_left = 1;
   int                    gap_left = 0;
   int                    ready_style = READY_ALWAYS;
   int                    style_left = 0;
   int unsigned           tick = 0;

   bitmap_id_allocator uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_id           (req_id),
      .req_entry_value  (req_entry_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_id    (rsp_result_id),
      .rsp_result_value (rsp_result_value),
      .rsp_status       (rsp_status),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic void predict_request(request_beat_type beat);
      int unsigned active;
      int unsigned words;
      int unsigned span;
      int unsigned w;
      int lowest;
      int b;
      logic [WORD_BITS-1:0] in_range;
      logic [WORD_BITS-1:0] free_bits;
      result_beat_type res;
      active = (id_limit > MAX_IDS) ? MAX_IDS : id_limit;
      words = (active + WORD_BITS - 1) / WORD_BITS;
      res.id = beat.id;
      res.value = '0;
      res.status = 1'b1;
      case (beat.mode)
         MODE_ALLOC: begin
            if (words != 0 && scan_ptr >= words)
               scan_ptr = 0;
            lowest = -1;
            for (w = 0; w < words && lowest < 0; w++) begin
               span = active - scan_ptr * WORD_BITS;
               in_range = (span >= WORD_BITS) ? '1 :
                          {WORD_BITS{1'b1}} >> (WORD_BITS - span);
               free_bits = ~used_bits[scan_ptr] & in_range;
               for (b = WORD_BITS - 1; b >= 0; b--)
                  if (free_bits[b])
                     lowest = b;
               if (lowest < 0)
                  scan_ptr = (scan_ptr + 1 >= words) ? 0 : scan_ptr + 1;
            end
            if (lowest >= 0) begin
               used_bits[scan_ptr][lowest] = 1'b1;
               res.id = ID_BITS'(scan_ptr * WORD_BITS + lowest);
               stored_value[res.id] = beat.value;
               res.status = 1'b0;
            end
         end
         MODE_FIND: begin
            if (beat.id < active && used_bits[beat.id / WORD_BITS][beat.id % WORD_BITS]) begin
               res.value = stored_value[beat.id];
               res.status = 1'b0;
            end
         end
         MODE_REMOVE: begin
            used_bits[beat.id / WORD_BITS][beat.id % WORD_BITS] = 1'b0;
            res.status = 1'b0;
         end
         default: ;
      endcase
      expected_results.push_back(res);
   endfunction

   // request driver, bursts with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            predict_request('{req_mode, req_id, req_entry_value});
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
               req_valid <= 1'b1;
               req_mode <= pending_reqs[0].mode;
               req_id <= pending_reqs[0].id;
               req_entry_value <= pending_reqs[0].value;
               void'(pending_reqs.pop_front());
               burst_left--;
               if (burst_left <= 0) begin
                  if ($urandom_range(0, 7) == 0) begin
                     burst_left = 40;
                     gap_left = 0;
                  end else begin
                     burst_left = $urandom_range(1, 16);
                     gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
                  end
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response stall pattern
   always @(posedge clock) begin
      tick++;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (style_left == 0) begin
            ready_style = $urandom_range(READY_ALWAYS, READY_SPARSE);
            style_left = $urandom_range(16, 96);
         end
         style_left--;
         case (ready_style)
            READY_ALWAYS: rsp_ready <= 1'b1;
            READY_RANDOM: rsp_ready <= ($urandom_range(0, 9) < 6);
            default:      rsp_ready <= (tick % 3 == 0);
         endcase
      end
   end

   // response monitor
   always @(posedge clock) begin
      result_beat_type exp_beat;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            $error("unexpected beat: id %0d value %h status %0d",
                   rsp_result_id, rsp_result_value, rsp_status);
            failed = 1'b1;
         end else begin
            exp_beat = expected_results.pop_front();
            if (rsp_result_id !== exp_beat.id) begin
               $error("result_id expected %0d actual %0d", exp_beat.id, rsp_result_id);
               failed = 1'b1;
            end
            if (rsp_result_value !== exp_beat.value) begin
               $error("result_value expected %h actual %h", exp_beat.value, rsp_result_value);
               failed = 1'b1;
            end
            if (rsp_status !== exp_beat.status) begin
               $error("status expected %0d actual %0d", exp_beat.status, rsp_status);
               failed = 1'b1;
            end
         end
      end
   end

   task automatic add_request(input logic [1:0] mode, input logic [7:0] id,
                              input logic [63:0] value);
      pending_reqs.push_back('{mode, id, value});
   endtask

   task automatic wait_idle();
      do
         @(negedge clock);
      while (pending_reqs.size() != 0 || req_valid || expected_results.size() != 0);
   endtask

   task automatic write_count(input int unsigned count_value);
      wait_idle();
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= 9'(count_value);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      id_limit = count_value;
      @(negedge clock);
   endtask

   task automatic add_random(input int items, input int alloc_pct);
      int unsigned lim;
      int unsigned pick;
      logic [1:0] mode;
      logic [7:0] id;
      lim = ((id_limit > MAX_IDS) ? MAX_IDS : id_limit) + 3;
      if (lim > 255)
         lim = 255;
      repeat (items) begin
         pick = $urandom_range(0, 99);
         if (pick < alloc_pct)
            mode = MODE_ALLOC;
         else if (pick < alloc_pct + (100 - alloc_pct) / 2)
            mode = MODE_FIND;
         else if (pick < 95)
            mode = MODE_REMOVE;
         else
            mode = MODE_UNKNOWN;
         id = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, lim)) : 8'($urandom);
         add_request(mode, id, {$urandom, $urandom});
      end
   endtask

   initial begin
      for (int i = 0; i < NWORDS; i++)
         used_bits[i] = '0;
      for (int i = 0; i < MAX_IDS; i++)
         stored_value[i] = '0;
      scan_ptr = 0;
      id_limit = MAX_IDS;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      add_request(MODE_ALLOC, 8'd77, '1);
      add_request(MODE_ALLOC, 8'd255, '0);
      add_request(MODE_FIND, 8'd0, '0);
      add_request(MODE_FIND, 8'd1, '1);
      add_request(MODE_FIND, 8'd255, '0);
      add_request(MODE_FIND, 8'd2, '0);
      add_request(MODE_REMOVE, 8'd0, '1);
      add_request(MODE_REMOVE, 8'd0, '0);
      add_request(MODE_FIND, 8'd0, '0);
      add_request(MODE_ALLOC, 8'd0, 64'h8000_0000_0000_0001);
      add_request(MODE_FIND, 8'd0, '1);
      add_request(MODE_UNKNOWN, 8'd255, '1);
      add_request(MODE_UNKNOWN, 8'd0, '0);
      add_request(MODE_REMOVE, 8'd255, '0);
      add_request(MODE_ALLOC, 8'd128, 64'hA5A5_5A5A_0F0F_F0F0);
      add_request(MODE_FIND, 8'd2, '0);
      add_request(MODE_FIND, 8'd128, '0);
      add_random(150, 60);

      write_count(1);
      add_random(60, 50);
      write_count(0);
      add_random(40, 50);
      write_count(37);
      add_random(150, 50);
      write_count(300);
      add_random(200, 85);
      write_count(511);
      add_random(150, 70);
      write_count(64);
      add_random(120, 50);
      write_count(33);
      add_random(100, 50);
      write_count(255);
      add_random(100, 60);

      wait_idle();
      repeat (20) @(posedge clock);
      if (!failed && expected_results.size() == 0)
         $display("bitmap_id_allocator: match");
      else
         $display("bitmap_id_allocator: mismatch");
      $finish;
   end

   initial begin
      #1_000_000;
      $display("bitmap_id_allocator: mismatch");
      $finish;
   end

endmodule

[filelist.f]
+incdir+hdl
hdl/bia_pkg.sv
hdl/bia_word_unit.sv
hdl/bia_value_ram.sv
hdl/bitmap_id_allocator.sv
verif/bitmap_id_allocator_tb.sv
